// File: sv/dblic_pkg.sv
// ----------------------------------------------------------------------------
// dblic_pkg
// Types and constants shared by the double-byte index converter modules.
// ----------------------------------------------------------------------------
package dblic_pkg;

  localparam int IDX_W = 16;

  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_LEAD   = 3'd1;
  localparam logic [2:0] FN_TRAIL  = 3'd2;
  localparam logic [2:0] FN_DECODE = 3'd3;
  localparam logic [2:0] FN_ENCODE = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ERR  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LSCAN,
    ST_DIV,
    ST_TSCAN,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic lstep;
    logic dstep;
    logic tstep;
    logic calc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic is_enc;
    logic lead_hit;
    logic lead_end;
    logic trail_hit;
    logic trail_end;
    logic div_end;
  } dps_t;

endpackage

// File: sv/dbcs_linear_index_converter_core.sv
// ----------------------------------------------------------------------------
// dbcs_linear_index_converter_core
// Converts characters between a double-byte encoding and a linear index.
// ----------------------------------------------------------------------------
// One word is handled at a time. Table loads, clears, ASCII and terminator
// cases go straight to the result. A multibyte decode runs the lead scan and
// the trail scan, which visit one table entry per cycle, and then the index
// calculation. A multibyte encode runs the lead scan, the bit-serial divider
// that splits the index into lead and trail offsets, and the trail scan. The
// next word is accepted while the previous result still waits on the output.
module dbcs_linear_index_converter_core #(
  parameter int MAX_LEAD_RANGES  = 8,
  parameter int MAX_TRAIL_RANGES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // range_low, range_high, lead_byte, trail_byte, char_index, index_is_ascii
  input  logic [55:0] s_tdata,
  // func
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, out_lead, out_trail, byte_count, out_index, out_ascii, is_end
  output logic [39:0] m_tdata
);
  import dblic_pkg::*;

  cmd_t cmd;
  dps_t dps;

  logic [1:0]  status;
  logic [7:0]  out_lead;
  logic [7:0]  out_trail;
  logic [1:0]  byte_count;
  logic [15:0] out_index;
  logic        out_ascii;
  logic        is_end;

  dblic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dps      (dps),
    .cmd      (cmd)
  );

  dblic_dp #(
    .MAX_LEAD_RANGES  (MAX_LEAD_RANGES),
    .MAX_TRAIL_RANGES (MAX_TRAIL_RANGES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .dps            (dps),
    .func           (s_tuser),
    .range_low      (s_tdata[7:0]),
    .range_high     (s_tdata[15:8]),
    .lead_byte      (s_tdata[23:16]),
    .trail_byte     (s_tdata[31:24]),
    .char_index     (s_tdata[47:32]),
    .index_is_ascii (s_tdata[48]),
    .status         (status),
    .out_lead       (out_lead),
    .out_trail      (out_trail),
    .byte_count     (byte_count),
    .out_index      (out_index),
    .out_ascii      (out_ascii),
    .is_end         (is_end)
  );

  assign m_tdata = {2'b00, is_end, out_ascii, out_index, byte_count,
                    out_trail, out_lead, status};

endmodule

// File: sv/dblic_dp.sv
// ----------------------------------------------------------------------------
// dblic_dp
// Range tables, scan registers, divider and result registers.
// ----------------------------------------------------------------------------
module dblic_dp #(
  parameter int MAX_LEAD_RANGES  = 8,
  parameter int MAX_TRAIL_RANGES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  dblic_pkg::cmd_t   cmd,
  output dblic_pkg::dps_t   dps,
  input  logic [2:0]        func,
  input  logic [7:0]        range_low,
  input  logic [7:0]        range_high,
  input  logic [7:0]        lead_byte,
  input  logic [7:0]        trail_byte,
  input  logic [15:0]       char_index,
  input  logic              index_is_ascii,
  output logic [1:0]        status,
  output logic [7:0]        out_lead,
  output logic [7:0]        out_trail,
  output logic [1:0]        byte_count,
  output logic [15:0]       out_index,
  output logic              out_ascii,
  output logic              is_end
);
  import dblic_pkg::*;

  localparam int LCW = $clog2(MAX_LEAD_RANGES + 1);
  localparam int LAW = (MAX_LEAD_RANGES > 1) ? $clog2(MAX_LEAD_RANGES) : 1;
  localparam int TCW = $clog2(MAX_TRAIL_RANGES + 1);
  localparam int TAW = (MAX_TRAIL_RANGES > 1) ? $clog2(MAX_TRAIL_RANGES) : 1;
  localparam int TW  = $clog2(MAX_TRAIL_RANGES * 256 + 1);
  localparam int SW  = 9 + TW;
  localparam int PW  = 8 + TW;

  logic [7:0]     lead_lo [MAX_LEAD_RANGES];
  logic [7:0]     lead_hi [MAX_LEAD_RANGES];
  logic [7:0]     trail_lo [MAX_TRAIL_RANGES];
  logic [7:0]     trail_hi [MAX_TRAIL_RANGES];
  logic [LCW-1:0] lead_count;
  logic [TCW-1:0] trail_count;
  logic [TW-1:0]  ttot;

  logic           enc;
  logic [7:0]     lb;
  logic [7:0]     tb;
  logic [15:0]    ci;
  logic [LCW-1:0] li;
  logic [TCW-1:0] tj;
  logic [31:0]    start;
  logic [7:0]     lo;
  logic [TW-1:0]  acc;
  logic [TW-1:0]  tpart;
  logic [15:0]    code;
  logic [TW-1:0]  rem;
  logic [3:0]     dcnt;

  logic [1:0]  r_status;
  logic [7:0]  r_lead;
  logic [7:0]  r_trail;
  logic [1:0]  r_cnt;
  logic [15:0] r_idx;
  logic        r_asc;
  logic        r_end;

  logic [7:0]    l_lo, l_hi, t_lo, t_hi;
  logic [8:0]    l_span, t_span;
  logic [SW-1:0] l_size;
  logic [31:0]   l_limit;
  logic          l_valid, t_valid, dec_lhit, enc_lhit, dec_thit, enc_thit;
  logic [TW:0]   t_limit, dsh, ddiff;
  logic [PW-1:0] prod;
  logic [31:0]   idx;

  assign l_lo    = lead_lo[li[LAW-1:0]];
  assign l_hi    = lead_hi[li[LAW-1:0]];
  assign l_span  = {1'b0, l_hi} - {1'b0, l_lo} + 9'd1;
  assign l_size  = SW'(l_span) * SW'(ttot);
  assign l_limit = start + 32'(l_size);
  assign l_valid = li < lead_count;
  assign dec_lhit = l_valid && (lb >= l_lo) && (lb <= l_hi);
  assign enc_lhit = l_valid && (l_size != '0) && ({16'd0, ci} >= start) &&
                    ({16'd0, ci} < l_limit);

  assign t_lo    = trail_lo[tj[TAW-1:0]];
  assign t_hi    = trail_hi[tj[TAW-1:0]];
  assign t_span  = {1'b0, t_hi} - {1'b0, t_lo} + 9'd1;
  assign t_valid = tj < trail_count;
  assign t_limit = (TW+1)'(acc) + (TW+1)'(t_span);
  assign dec_thit = t_valid && (tb >= t_lo) && (tb <= t_hi);
  assign enc_thit = t_valid && (rem >= acc) && ((TW+1)'(rem) < t_limit);

  assign dsh   = {rem, code[15]};
  assign ddiff = dsh - {1'b0, ttot};

  assign prod = PW'(lb - lo) * PW'(ttot);
  assign idx  = start + 32'(prod) + 32'(tpart);

  always_comb begin
    dps.need_scan = ((func == FN_DECODE) && (lead_byte >= ASCII_LIMIT)) ||
                    ((func == FN_ENCODE) && !index_is_ascii && (char_index != '0));
    dps.is_enc    = enc;
    dps.lead_hit  = enc ? enc_lhit : dec_lhit;
    dps.lead_end  = ({1'b0, li} + 1'b1) >= {1'b0, lead_count};
    dps.trail_hit = enc ? enc_thit : dec_thit;
    dps.trail_end = ({1'b0, tj} + 1'b1) >= {1'b0, trail_count};
    dps.div_end   = dcnt == 4'd15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_count  <= '0;
      trail_count <= '0;
      ttot        <= '0;
    end else if (cmd.load) begin
      case (func)
        FN_CLEAR: begin
          lead_count  <= '0;
          trail_count <= '0;
          ttot        <= '0;
        end
        FN_LEAD: begin
          if ((lead_count < LCW'(MAX_LEAD_RANGES)) && (range_low <= range_high)) begin
            lead_count <= lead_count + 1'b1;
          end
        end
        FN_TRAIL: begin
          if ((trail_count < TCW'(MAX_TRAIL_RANGES)) && (range_low <= range_high)) begin
            trail_count <= trail_count + 1'b1;
            ttot <= ttot + TW'(range_high) - TW'(range_low) + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (func == FN_LEAD) && (lead_count < LCW'(MAX_LEAD_RANGES))) begin
      lead_lo[lead_count[LAW-1:0]] <= range_low;
      lead_hi[lead_count[LAW-1:0]] <= range_high;
    end
    if (cmd.load && (func == FN_TRAIL) && (trail_count < TCW'(MAX_TRAIL_RANGES))) begin
      trail_lo[trail_count[TAW-1:0]] <= range_low;
      trail_hi[trail_count[TAW-1:0]] <= range_high;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      enc   <= func == FN_ENCODE;
      lb    <= lead_byte;
      tb    <= trail_byte;
      ci    <= char_index;
      li    <= '0;
      tj    <= '0;
      start <= 32'd1;
      acc   <= '0;
      rem   <= '0;
      dcnt  <= '0;
      r_status <= STAT_OK;
      r_lead   <= '0;
      r_trail  <= '0;
      r_cnt    <= 2'd0;
      r_idx    <= '0;
      r_asc    <= 1'b0;
      r_end    <= 1'b0;
      case (func)
        FN_CLEAR: ;
        FN_LEAD: begin
          if (lead_count >= LCW'(MAX_LEAD_RANGES)) r_status <= STAT_FULL;
          else if (range_low > range_high) r_status <= STAT_ERR;
        end
        FN_TRAIL: begin
          if (trail_count >= TCW'(MAX_TRAIL_RANGES)) r_status <= STAT_FULL;
          else if (range_low > range_high) r_status <= STAT_ERR;
        end
        FN_DECODE: begin
          if (lead_byte == '0) begin
            r_end <= 1'b1;
            r_cnt <= 2'd1;
          end else if (lead_byte < ASCII_LIMIT) begin
            r_idx <= {8'd0, lead_byte};
            r_asc <= 1'b1;
            r_cnt <= 2'd1;
          end else begin
            r_status <= STAT_ERR;
          end
        end
        FN_ENCODE: begin
          if (index_is_ascii) begin
            r_lead <= char_index[7:0];
            r_cnt  <= 2'd1;
          end else if (char_index == '0) begin
            r_end <= 1'b1;
            r_cnt <= 2'd1;
          end else begin
            r_status <= STAT_ERR;
          end
        end
        default: r_status <= STAT_ERR;
      endcase
    end

    if (cmd.lstep) begin
      li <= li + 1'b1;
      if (dps.lead_hit) begin
        lo   <= l_lo;
        code <= ci - start[15:0];
      end else begin
        start <= l_limit;
      end
    end

    // Restoring division of the code by the trail total, one quotient bit a cycle.
    if (cmd.dstep) begin
      dcnt <= dcnt + 1'b1;
      if (!ddiff[TW] || (dsh >= {1'b0, ttot})) begin
        rem  <= ddiff[TW-1:0];
        code <= {code[14:0], 1'b1};
      end else begin
        rem  <= dsh[TW-1:0];
        code <= {code[14:0], 1'b0};
      end
    end

    if (cmd.tstep) begin
      tj <= tj + 1'b1;
      if (dps.trail_hit) begin
        if (enc) begin
          r_status <= STAT_OK;
          r_lead   <= code[7:0] + lo;
          r_trail  <= rem[7:0] - acc[7:0] + t_lo;
          r_cnt    <= 2'd2;
        end else begin
          tpart <= TW'(tb) - TW'(t_lo) + acc;
        end
      end else begin
        acc <= t_limit[TW-1:0];
      end
    end

    if (cmd.calc && (idx <= 32'h0000_FFFF)) begin
      r_status <= STAT_OK;
      r_idx    <= idx[15:0];
      r_cnt    <= 2'd2;
    end

    if (cmd.finish) begin
      status     <= r_status;
      out_lead   <= r_lead;
      out_trail  <= r_trail;
      byte_count <= r_cnt;
      out_index  <= r_idx;
      out_ascii  <= r_asc;
      is_end     <= r_end;
    end
  end

endmodule

// File: sv/dblic_ctrl.sv
// ----------------------------------------------------------------------------
// dblic_ctrl
// Sequencer for the lead scan, divide, trail scan and result hand-off.
// ----------------------------------------------------------------------------
module dblic_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  dblic_pkg::dps_t dps,
  output dblic_pkg::cmd_t cmd
);
  import dblic_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = dps.need_scan ? ST_LSCAN : ST_DONE;
      ST_LSCAN: begin
        if (dps.lead_hit) state_next = dps.is_enc ? ST_DIV : ST_TSCAN;
        else if (dps.lead_end) state_next = ST_DONE;
      end
      ST_DIV:   if (dps.div_end) state_next = ST_TSCAN;
      ST_TSCAN: begin
        if (dps.trail_hit) state_next = dps.is_enc ? ST_DONE : ST_CALC;
        else if (dps.trail_end) state_next = ST_DONE;
      end
      ST_CALC:  state_next = ST_DONE;
      ST_DONE:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = state == ST_IDLE;
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && s_tvalid;
    cmd.lstep  = state == ST_LSCAN;
    cmd.dstep  = state == ST_DIV;
    cmd.tstep  = state == ST_TSCAN;
    cmd.calc   = state == ST_CALC;
    cmd.finish = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  a_direct: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && s_tvalid && !dps.need_scan) |=> state == ST_DONE)
    else $error("item without a scan did not go straight to the result");
  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result overwrote a word still waiting");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && dps.div_end) |=> state == ST_TSCAN)
    else $error("divide did not hand over to the trail scan");
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("output word raised outside the result state");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives table loads, decodes and encodes into the index converter and
// checks every result word against an in-bench model of the range tables.
// ----------------------------------------------------------------------------

import dblic_pkg::*;

typedef struct packed {
  logic [2:0] func;
  logic [7:0] rlow;
  logic [7:0] rhigh;
  logic [7:0] lead;
  logic [7:0] trail;
  logic [15:0] cidx;
  logic asc;
} char_req_t;

typedef struct packed {
  logic [1:0] status;
  logic [7:0] olead;
  logic [7:0] otrail;
  logic [1:0] cnt;
  logic [15:0] oidx;
  logic oasc;
  logic oend;
} char_rsp_t;

class charset_scoreboard;
  logic [7:0] lead_lo[8];
  logic [7:0] lead_hi[8];
  logic [7:0] trail_lo[4];
  logic [7:0] trail_hi[4];
  int lead_n;
  int trail_n;
  char_rsp_t pending[$];
  int errors;

  function new();
    lead_n = 0;
    trail_n = 0;
    errors = 0;
  endfunction

  function int trail_sum();
    int t;
    t = 0;
    for (int j = 0; j < trail_n; j++) t += trail_hi[j] - trail_lo[j] + 1;
    return t;
  endfunction

  // Work out the result of one accepted request and update the tables.
  function void note_request(char_req_t r);
    char_rsp_t o;
    int tt, start, lo, acc, tpart, idx, code, tm, sz, tc;
    bit lf, tf, found;
    o = '0;
    tt = trail_sum();
    case (r.func)
      FN_CLEAR: begin
        lead_n = 0;
        trail_n = 0;
      end
      FN_LEAD: begin
        if (lead_n >= 8) o.status = STAT_FULL;
        else if (r.rlow > r.rhigh) o.status = STAT_ERR;
        else begin
          lead_lo[lead_n] = r.rlow;
          lead_hi[lead_n] = r.rhigh;
          lead_n++;
        end
      end
      FN_TRAIL: begin
        if (trail_n >= 4) o.status = STAT_FULL;
        else if (r.rlow > r.rhigh) o.status = STAT_ERR;
        else begin
          trail_lo[trail_n] = r.rlow;
          trail_hi[trail_n] = r.rhigh;
          trail_n++;
        end
      end
      FN_DECODE: begin
        if (r.lead == 0) begin
          o.oend = 1;
          o.cnt = 1;
        end else if (r.lead < ASCII_LIMIT) begin
          o.oidx = r.lead;
          o.oasc = 1;
          o.cnt = 1;
        end else begin
          start = 1; lf = 0; tf = 0; lo = 0; acc = 0; tpart = 0;
          for (int i = 0; i < lead_n; i++) begin
            if (r.lead >= lead_lo[i] && r.lead <= lead_hi[i]) begin
              lf = 1; lo = lead_lo[i]; break;
            end
            start += (lead_hi[i] - lead_lo[i] + 1) * tt;
          end
          for (int j = 0; lf && j < trail_n; j++) begin
            if (r.trail >= trail_lo[j] && r.trail <= trail_hi[j]) begin
              tf = 1; tpart = r.trail - trail_lo[j] + acc; break;
            end
            acc += trail_hi[j] - trail_lo[j] + 1;
          end
          if (lf && tf) begin
            idx = start + (r.lead - lo) * tt + tpart;
            if (idx > 65535) o.status = STAT_ERR;
            else begin
              o.oidx = 16'(idx);
              o.cnt = 2;
            end
          end else o.status = STAT_ERR;
        end
      end
      FN_ENCODE: begin
        if (r.asc) begin
          o.olead = r.cidx[7:0];
          o.cnt = 1;
        end else if (r.cidx == 0) begin
          o.oend = 1;
          o.cnt = 1;
        end else begin
          start = 1; found = 0;
          for (int i = 0; i < lead_n; i++) begin
            sz = (lead_hi[i] - lead_lo[i] + 1) * tt;
            if (sz > 0 && r.cidx >= start && r.cidx < start + sz) begin
              code = r.cidx - start;
              tm = code % tt;
              acc = 0;
              o.olead = 8'((code / tt) + lead_lo[i]);
              for (int j = 0; j < trail_n; j++) begin
                tc = trail_hi[j] - trail_lo[j] + 1;
                if (tm >= acc && tm < acc + tc) begin
                  o.otrail = 8'(tm - acc + trail_lo[j]);
                  found = 1;
                  break;
                end
                acc += tc;
              end
              break;
            end
            start += sz;
          end
          if (found) o.cnt = 2;
          else begin
            o.status = STAT_ERR;
            o.olead = 0;
            o.otrail = 0;
          end
        end
      end
      default: o.status = STAT_ERR;
    endcase
    pending.push_back(o);
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_result(char_rsp_t g);
    char_rsp_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result word %h", g));
      return;
    end
    e = pending.pop_front();
    if (g.status !== e.status) report($sformatf("status %0d, want %0d", g.status, e.status));
    if (g.olead !== e.olead) report($sformatf("out_lead %h, want %h", g.olead, e.olead));
    if (g.otrail !== e.otrail) report($sformatf("out_trail %h, want %h", g.otrail, e.otrail));
    if (g.cnt !== e.cnt) report($sformatf("byte_count %0d, want %0d", g.cnt, e.cnt));
    if (g.oidx !== e.oidx) report($sformatf("out_index %0d, want %0d", g.oidx, e.oidx));
    if (g.oasc !== e.oasc) report($sformatf("out_ascii %b, want %b", g.oasc, e.oasc));
    if (g.oend !== e.oend) report($sformatf("is_end %b, want %b", g.oend, e.oend));
  endtask
endclass

module testbench;
  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [55:0] s_tdata;
  logic [2:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [39:0] m_tdata;

  charset_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  bit stim_done;
  int quiet_cycles;

  dbcs_linear_index_converter_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // The result word carries status in its lowest bits, is_end highest.
  function automatic char_rsp_t unpack_rsp(logic [39:0] w);
    char_rsp_t g;
    g.status = w[1:0];
    g.olead  = w[9:2];
    g.otrail = w[17:10];
    g.cnt    = w[19:18];
    g.oidx   = w[35:20];
    g.oasc   = w[36];
    g.oend   = w[37];
    return g;
  endfunction

  // Send one word; valid stays high across back-to-back words.
  task automatic send_word(char_req_t r);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= r.func;
    s_tdata <= {7'd0, r.asc, r.cidx, r.trail, r.lead, r.rhigh, r.rlow};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] f, logic [7:0] a, logic [7:0] b,
                         logic [15:0] ci, logic asc);
    char_req_t r;
    r = '{f, a, b, a, b, ci, asc};
    send_word(r);
  endtask

  task automatic send_random_op();
    char_req_t r;
    int k;
    r = char_req_t'(52'({$urandom, $urandom}));
    k = $urandom_range(99, 0);
    if (k < 2) r.func = FN_CLEAR;
    else if (k < 8) r.func = FN_LEAD;
    else if (k < 12) r.func = FN_TRAIL;
    else if (k < 55) r.func = FN_DECODE;
    else if (k < 97) r.func = FN_ENCODE;
    else r.func = 3'($urandom_range(7, 5));
    if (r.func == FN_DECODE && $urandom_range(3, 0) != 0) r.lead[7] = 1;
    if (r.func == FN_ENCODE) begin
      r.asc = ($urandom_range(9, 0) == 0);
      if ($urandom_range(3, 0) != 0) r.cidx = 16'($urandom_range(4000, 0));
    end
    send_word(r);
  endtask

  // Reload a small random table set so that most codes hit a range.
  task automatic load_tables();
    int lo;
    send_op(FN_CLEAR, 0, 0, 0, 0);
    repeat ($urandom_range(4, 1)) begin
      lo = $urandom_range(250, 128);
      send_op(FN_LEAD, 8'(lo), 8'(lo + $urandom_range(5, 0)), 0, 0);
    end
    repeat ($urandom_range(4, 1)) begin
      lo = $urandom_range(250, 0);
      send_op(FN_TRAIL, 8'(lo), 8'(lo + $urandom_range(5, 0)), 0, 0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(unpack_rsp(m_tdata));
  end

  always @(negedge clk) begin
    if (hold_off || (recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct))
      m_tready <= 0;
    else
      m_tready <= 1;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("dbcs_linear_index_converter_core verification failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
    hold_off = 0; stim_done = 0;
    send_idle_pct = 8; recv_idle_pct = 76;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: no trail ranges, then full tables and the edge cases.
    send_op(FN_LEAD, 8'h81, 8'h82, 0, 0);
    send_op(FN_DECODE, 8'h81, 8'h40, 0, 0);
    send_op(FN_ENCODE, 0, 0, 16'd5, 0);
    send_op(FN_TRAIL, 8'h40, 8'h7e, 0, 0);
    send_op(FN_TRAIL, 8'h80, 8'hfe, 0, 0);
    send_op(FN_TRAIL, 8'h20, 8'h10, 0, 0);
    send_op(FN_TRAIL, 8'h00, 8'hff, 0, 0);
    send_op(FN_TRAIL, 8'h00, 8'h00, 0, 0);
    send_op(FN_TRAIL, 8'h01, 8'h01, 0, 0);
    for (int i = 0; i < 7; i++) send_op(FN_LEAD, 8'(8'h80 + 16 * i), 8'(8'h8f + 16 * i), 0, 0);
    send_op(FN_LEAD, 8'hff, 8'hff, 0, 0);
    send_op(FN_DECODE, 8'h00, 8'h00, 0, 0);
    send_op(FN_DECODE, 8'h7f, 8'hff, 0, 0);
    send_op(FN_DECODE, 8'h81, 8'hff, 0, 0);
    send_op(FN_DECODE, 8'hff, 8'hff, 0, 0);
    send_op(FN_ENCODE, 0, 0, 16'hffff, 1);
    send_op(FN_ENCODE, 0, 0, 16'h0000, 0);
    send_op(FN_ENCODE, 0, 0, 16'hffff, 0);
    send_op(FN_ENCODE, 0, 0, 16'd1, 0);
    send_op(3'd7, 8'hff, 8'hff, 16'hffff, 1);

    // Fill the block while the receiver holds off.
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_random_op();
    join

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 76; recv_idle_pct = 8; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int n = 0; n < 480; n++) begin
        if (n % 60 == 0) load_tables();
        send_random_op();
      end
    end
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("dbcs_linear_index_converter_core verification clean");
    else
      $display("dbcs_linear_index_converter_core verification failed");
    $finish;
  end
endmodule
